### hw/rtl/sli_pkg.sv
// Shared types and codes for the sorted list insert/delete block.
// Used by the controller, the datapath and the top level; no dependencies.
package sli_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam int VALUE_W = 32;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 5;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // commit the list update and load the result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;   // result register empty or being drained this cycle
   } dp_status_type;

endpackage

### hw/rtl/sli_ctrl.sv
// Controller state machine for the sorted list block.
// Depends on sli_pkg; drives command bits into sli_datapath.
module sli_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sli_pkg::dp_status_type status,
   output sli_pkg::dp_cmd_type   cmd
);

   sli_pkg::state_type state_ff;
   sli_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         sli_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sli_pkg::ST_EXEC;
            end
         end
         sli_pkg::ST_EXEC: begin
            // hold the item until the result register can take it
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = sli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sli_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/sli_datapath.sv
// Datapath of the sorted list block: entry array, parallel compare, shift, result register.
// Depends on sli_pkg; sequenced by sli_ctrl through dp_cmd_type.
module sli_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sli_pkg::dp_cmd_type                  cmd,
   output sli_pkg::dp_status_type               status,
   input  logic [1:0]                           req_cmd,
   input  logic signed [sli_pkg::VALUE_W-1:0]   req_value,
   input  logic [sli_pkg::RANK_W-1:0]           req_rank,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ok,
   output logic [sli_pkg::COUNT_W-1:0]          rsp_count,
   output logic signed [sli_pkg::VALUE_W-1:0]   rsp_read_value
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VW    = sli_pkg::VALUE_W;

   logic [1:0]                    cmd_ff;
   logic signed [VW-1:0]          value_ff;
   logic [sli_pkg::RANK_W-1:0]    rank_ff;
   logic signed [VW-1:0]          entry_ff [DEPTH];
   logic signed [VW-1:0]          entry_in [DEPTH];
   logic [CNT_W-1:0]              held_ff;
   logic [CNT_W-1:0]              held_in;
   logic                          rsp_valid_ff;
   logic                          ok_ff;
   logic                          ok_in;
   logic [sli_pkg::COUNT_W-1:0]   count_ff;
   logic signed [VW-1:0]          rd_ff;
   logic signed [VW-1:0]          rd_in;

   logic [DEPTH-1:0]              live;
   logic [DEPTH-1:0]              lt;
   logic [DEPTH-1:0]              eq;
   logic [DEPTH-1:0]              prev_lt;
   logic signed [VW-1:0]          up_e   [DEPTH];
   logic signed [VW-1:0]          down_e [DEPTH];
   logic                          full;
   logic                          found;
   logic [CNT_W+sli_pkg::RANK_W-1:0] rank_w;
   logic [CNT_W+sli_pkg::RANK_W-1:0] held_w;
   logic [CNT_W+sli_pkg::COUNT_W-1:0] count_w;

   // neighbor taps for the insert and remove shifts
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_tap
         if (g == 0) begin : g_first
            assign up_e[g] = value_ff;
         end else begin : g_rest
            assign up_e[g] = entry_ff[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign down_e[g] = entry_ff[g];
         end else begin : g_inner
            assign down_e[g] = entry_ff[g+1];
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = CNT_W'(i) < held_ff;
         lt[i]   = live[i] && (entry_ff[i] < value_ff);
         eq[i]   = live[i] && (entry_ff[i] == value_ff);
      end
   end

   // list is ascending, so lt is a prefix and any match sits right after it
   assign prev_lt = {lt[DEPTH-2:0], 1'b1};
   assign full    = held_ff == CNT_W'(DEPTH);
   assign found   = |eq;
   assign rank_w  = {{CNT_W{1'b0}}, rank_ff};
   assign held_w  = {{sli_pkg::RANK_W{1'b0}}, held_ff};

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      held_in = held_ff;
      ok_in   = 1'b0;
      rd_in   = '0;
      case (cmd_ff)
         sli_pkg::CMD_INSERT: begin
            if (!full) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (!lt[i]) begin
                     entry_in[i] = prev_lt[i] ? value_ff : up_e[i];
                  end
               end
               held_in = held_ff + CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         sli_pkg::CMD_REMOVE: begin
            if (found) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (!lt[i]) begin
                     entry_in[i] = down_e[i];
                  end
               end
               held_in = held_ff - CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         sli_pkg::CMD_READ: begin
            if (rank_w < held_w) begin
               rd_in = entry_ff[rank_w[IDX_W-1:0]];
               ok_in = 1'b1;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign count_w = {{sli_pkg::COUNT_W{1'b0}}, held_in};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         rank_ff  <= req_rank;
      end
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
         ok_ff    <= ok_in;
         count_ff <= count_w[sli_pkg::COUNT_W-1:0];
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            held_ff <= held_in;
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_count       = count_ff;
   assign rsp_read_value  = rd_ff;

endmodule

### hw/rtl/sorted_list_insert_delete_core.sv
// Top level of the sorted list insert/delete block.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, req_cmd, value, rank   | in
//   rsp     | rsp_valid/ready, rsp_ok, count, read_value | out
//
// Each item is first captured from the request; then all live entries are compared
// in parallel and the entry array is shifted, or a read picks the entry at its rank.
// Reset empties the list at once; entry contents are left as they are.
// A result waits in an output register; one more item is accepted meanwhile and
// holds in its compare/shift step until that register frees up.
module sorted_list_insert_delete_core #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic signed [sli_pkg::VALUE_W-1:0]  req_value,
   input  logic [sli_pkg::RANK_W-1:0]          req_rank,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [sli_pkg::COUNT_W-1:0]         rsp_count,
   output logic signed [sli_pkg::VALUE_W-1:0]  rsp_read_value
);

   sli_pkg::dp_cmd_type    dp_cmd;
   sli_pkg::dp_status_type dp_status;

   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sli_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_rank       (req_rank),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

endmodule

### hw/rtl/sli_checker.sv
// Port-level checks for the sorted list block, bound to the top level.
// Depends on sli_pkg; sees only the ports of sorted_list_insert_delete_core.
module sli_checker #(
   parameter int DEPTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_ok,
   input logic [sli_pkg::COUNT_W-1:0]         rsp_count,
   input logic signed [sli_pkg::VALUE_W-1:0]  rsp_read_value
);

   // a stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_count)
         && $stable(rsp_read_value))
      else $error("stalled result changed");

   // every accepted item moves on to the compare/shift step before another is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on back-to-back cycles");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 31) || (rsp_count <= sli_pkg::COUNT_W'(DEPTH)))
      else $error("count exceeds list depth");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == '0)
      else $error("failed item returned nonzero read value");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

endmodule

bind sorted_list_insert_delete_core sli_checker #(
   .DEPTH (DEPTH)
) u_sli_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ok         (rsp_ok),
   .rsp_count      (rsp_count),
   .rsp_read_value (rsp_read_value)
);
